// ----- hdl/mrrc_pkg.sv -----
`default_nettype none
package mrrc_pkg;

  // Number of register words in one read response.
  localparam int REG_COUNT = 8;

  // Frame layout: address, function, byte count, the words, CRC low, CRC high.
  localparam int FULL_FRAME_LEN = 2 * REG_COUNT + 5;

  // Word index and RAM address widths. The RAM holds two banks of words.
  localparam int IDX_W  = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam int RAM_DEPTH = 2 * REG_COUNT;
  localparam int ADDR_W = $clog2(RAM_DEPTH);

  localparam logic [7:0]  LEN_FIRST_WORD = 8'd3;
  localparam logic [7:0]  LEN_CRC_LO     = 8'(FULL_FRAME_LEN - 2);
  localparam logic [7:0]  LEN_CRC_HI     = 8'(FULL_FRAME_LEN - 1);
  localparam logic [7:0]  LEN_EXACT      = 8'(FULL_FRAME_LEN);
  localparam logic [7:0]  LEN_MIN        = 8'd5;
  localparam logic [7:0]  LEN_MAX        = 8'd255;
  localparam logic [7:0]  BYTE_COUNT_OK  = 8'(2 * REG_COUNT);
  localparam logic [7:0]  FUNC_READ      = 8'h03;
  localparam logic [7:0]  FUNC_EXCEPTION = 8'h83;
  localparam logic [7:0]  SLAVE_RESET    = 8'h01;
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'hA001;
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(REG_COUNT - 1);

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_SHORT      = 3'd1,
    ST_ADDRESS    = 3'd2,
    ST_EXCEPTION  = 3'd3,
    ST_FUNCTION   = 3'd4,
    ST_LENGTH     = 3'd5,
    ST_BYTE_COUNT = 3'd6,
    ST_CRC        = 3'd7
  } status_t;

  // One finished frame, as handed from the front to the back.
  typedef struct packed {
    status_t    status;
    logic [7:0] exception_code;
    logic       bank;
  } frame_entry_t;

  // Queue state seen by the front and the back.
  typedef struct packed {
    logic empty;
    logic full;
  } queue_state_t;

  // CRC16 update over one byte, reflected polynomial, LSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/mrrc_ifs.sv -----
`default_nettype none
// Frame byte channel.
interface mrrc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       end_of_frame;
  modport source (output valid, output rx_byte, output end_of_frame, input ready);
  modport sink (input valid, input rx_byte, input end_of_frame, output ready);
endinterface

// Result channel.
interface mrrc_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  exception_code;
  logic [2:0]  reg_index;
  logic [15:0] reg_value;
  logic        last;
  modport source (output valid, output status, output exception_code, output reg_index,
                  output reg_value, output last, input ready);
  modport sink (input valid, input status, input exception_code, input reg_index,
                input reg_value, input last, output ready);
endinterface

// Configuration write channel for the slave address.
interface mrrc_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hdl/modbus_read_response_checker_core.sv -----
// Channel   Role    Payload                                              Moves when
// rx        sink    rx_byte[7:0], end_of_frame                           valid && ready
// result    source  status[2:0], exception_code[7:0], reg_index[2:0],    valid && ready
//                   reg_value[15:0], last
// cfg       sink    data[7:0] (slave address)                            valid && ready
//
// One frame byte is taken per cycle unless the byte channel stalls; the CRC and
// all frame fields update in the cycle of its transaction. Results leave at one
// per cycle while result.ready is high, REG_COUNT word transactions for a good
// frame or one status transaction for a bad one, via queue and result register.
// The byte channel stalls only while two finished frames still wait for output.
// Reset is synchronous and active high and sets the slave address to 1.
`default_nettype none
module modbus_read_response_checker_core (
  input  wire logic     clk,
  input  wire logic     rst,
  mrrc_byte_if.sink     rx,
  mrrc_result_if.source result,
  mrrc_cfg_if.sink      cfg
);

  // Slave address register. Writes are always taken.
  logic [7:0] slave_address;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= mrrc_pkg::SLAVE_RESET;
    end else if (cfg.valid && cfg.ready) begin
      slave_address <= cfg.data;
    end
  end

  // Front to back hand-off through the frame queue and the word RAM.
  mrrc_pkg::frame_entry_t push_entry;
  mrrc_pkg::frame_entry_t head;
  mrrc_pkg::queue_state_t q_state;
  logic                   push;
  logic                   pop;

  logic                          ram_we;
  logic [mrrc_pkg::ADDR_W-1:0]   ram_waddr;
  logic [15:0]                   ram_wdata;
  logic                          ram_re;
  logic [mrrc_pkg::ADDR_W-1:0]   ram_raddr;
  logic [15:0]                   ram_rdata;

  // The front owns the bank the current frame is writing; a bank is free
  // again once the back has issued the last read of its frame.
  mrrc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .rx            (rx),
    .slave_address (slave_address),
    .q_state       (q_state),
    .push          (push),
    .push_entry    (push_entry),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata)
  );

  mrrc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_state    (q_state)
  );

  mrrc_ram #(
    .WIDTH (16),
    .DEPTH (mrrc_pkg::RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The RAM read data doubles as the word payload of the result register,
  // so reads are issued only when the result register advances.
  mrrc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_state   (q_state),
    .pop       (pop),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .result    (result)
  );

endmodule
`default_nettype wire

// ----- hdl/mrrc_ram.sv -----
`default_nettype none
// Simple dual-port RAM: one write port, one read port with registered data.
module mrrc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- hdl/mrrc_front.sv -----
`default_nettype none
// Frame parser: tracks the frame fields, writes register words into the
// current RAM bank and classifies the frame at its last byte.
module mrrc_front (
  input  wire logic                         clk,
  input  wire logic                         rst,
  mrrc_byte_if.sink                         rx,
  input  wire logic [7:0]                   slave_address,
  input  wire mrrc_pkg::queue_state_t       q_state,
  output logic                              push,
  output mrrc_pkg::frame_entry_t            push_entry,
  output logic                              ram_we,
  output logic [mrrc_pkg::ADDR_W-1:0]       ram_waddr,
  output logic [15:0]                       ram_wdata
);

  logic [7:0]  frame_length;
  logic [15:0] running_crc;
  logic [15:0] received_crc;
  logic [7:0]  address_byte;
  logic [7:0]  function_byte;
  logic [7:0]  count_byte;
  logic [7:0]  pending_high_byte;
  logic        wr_bank;

  logic [7:0]  frame_length_next;
  logic [15:0] running_crc_next;
  logic [15:0] received_crc_next;
  logic [7:0]  address_byte_next;
  logic [7:0]  function_byte_next;
  logic [7:0]  count_byte_next;
  logic [7:0]  pending_high_byte_next;

  logic        accept;
  logic        in_words;
  logic [7:0]  word_pos;
  mrrc_pkg::status_t status;

  assign rx.ready = !q_state.full;
  assign accept   = rx.valid && rx.ready;
  assign in_words = (frame_length >= mrrc_pkg::LEN_FIRST_WORD) &&
                    (frame_length < mrrc_pkg::LEN_CRC_LO);
  assign word_pos = frame_length - mrrc_pkg::LEN_FIRST_WORD;

  always_comb begin
    address_byte_next      = address_byte;
    function_byte_next     = function_byte;
    count_byte_next        = count_byte;
    pending_high_byte_next = pending_high_byte;
    received_crc_next      = received_crc;
    running_crc_next       = running_crc;
    if (frame_length == 8'd0) begin
      address_byte_next = rx.rx_byte;
    end else if (frame_length == 8'd1) begin
      function_byte_next = rx.rx_byte;
    end else if (frame_length == 8'd2) begin
      count_byte_next = rx.rx_byte;
    end else if (in_words) begin
      if (!word_pos[0]) begin
        pending_high_byte_next = rx.rx_byte;
      end
    end else if (frame_length == mrrc_pkg::LEN_CRC_LO) begin
      received_crc_next = {received_crc[15:8], rx.rx_byte};
    end else if (frame_length == mrrc_pkg::LEN_CRC_HI) begin
      received_crc_next = {rx.rx_byte, received_crc[7:0]};
    end
    if (frame_length < mrrc_pkg::LEN_CRC_LO) begin
      running_crc_next = mrrc_pkg::crc_byte(running_crc, rx.rx_byte);
    end
    frame_length_next = (frame_length == mrrc_pkg::LEN_MAX) ? frame_length
                                                            : frame_length + 8'd1;
  end

  // Checks in priority order, on the values that include the current byte.
  always_comb begin
    if (frame_length_next < mrrc_pkg::LEN_MIN) begin
      status = mrrc_pkg::ST_SHORT;
    end else if (address_byte_next != slave_address) begin
      status = mrrc_pkg::ST_ADDRESS;
    end else if (function_byte_next == mrrc_pkg::FUNC_EXCEPTION) begin
      status = mrrc_pkg::ST_EXCEPTION;
    end else if (function_byte_next != mrrc_pkg::FUNC_READ) begin
      status = mrrc_pkg::ST_FUNCTION;
    end else if (frame_length_next != mrrc_pkg::LEN_EXACT) begin
      status = mrrc_pkg::ST_LENGTH;
    end else if (count_byte_next != mrrc_pkg::BYTE_COUNT_OK) begin
      status = mrrc_pkg::ST_BYTE_COUNT;
    end else if (received_crc_next != running_crc_next) begin
      status = mrrc_pkg::ST_CRC;
    end else begin
      status = mrrc_pkg::ST_OK;
    end
  end

  assign push                      = accept && rx.end_of_frame;
  assign push_entry.status         = status;
  assign push_entry.exception_code = (status == mrrc_pkg::ST_EXCEPTION) ? count_byte_next
                                                                         : 8'h00;
  assign push_entry.bank           = wr_bank;

  assign ram_we    = accept && in_words && word_pos[0];
  assign ram_wdata = {pending_high_byte, rx.rx_byte};
  assign ram_waddr = wr_bank
      ? mrrc_pkg::ADDR_W'(mrrc_pkg::REG_COUNT) + mrrc_pkg::ADDR_W'(word_pos[7:1])
      : mrrc_pkg::ADDR_W'(word_pos[7:1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_length      <= 8'd0;
      running_crc       <= mrrc_pkg::CRC_INIT;
      received_crc      <= 16'h0000;
      address_byte      <= 8'd0;
      function_byte     <= 8'd0;
      count_byte        <= 8'd0;
      pending_high_byte <= 8'd0;
      wr_bank           <= 1'b0;
    end else if (accept) begin
      if (rx.end_of_frame) begin
        frame_length      <= 8'd0;
        running_crc       <= mrrc_pkg::CRC_INIT;
        received_crc      <= 16'h0000;
        address_byte      <= 8'd0;
        function_byte     <= 8'd0;
        count_byte        <= 8'd0;
        pending_high_byte <= 8'd0;
        wr_bank           <= !wr_bank;
      end else begin
        frame_length      <= frame_length_next;
        running_crc       <= running_crc_next;
        received_crc      <= received_crc_next;
        address_byte      <= address_byte_next;
        function_byte     <= function_byte_next;
        count_byte        <= count_byte_next;
        pending_high_byte <= pending_high_byte_next;
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/mrrc_queue.sv -----
`default_nettype none
// Two-entry queue of finished frames between the front and the back.
module mrrc_queue (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  input  wire mrrc_pkg::frame_entry_t push_entry,
  input  wire logic                   pop,
  output mrrc_pkg::frame_entry_t      head,
  output mrrc_pkg::queue_state_t      q_state
);

  mrrc_pkg::frame_entry_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign head          = slots[rd_ptr];
  assign q_state.empty = (count == 2'd0);
  assign q_state.full  = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/mrrc_back.sv -----
`default_nettype none
// Result sequencer: turns the head frame into one status item or into the
// register words read back from its RAM bank, one item per cycle while result.ready is high.
module mrrc_back (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire mrrc_pkg::frame_entry_t   head,
  input  wire mrrc_pkg::queue_state_t   q_state,
  output logic                          pop,
  output logic                          ram_re,
  output logic [mrrc_pkg::ADDR_W-1:0]   ram_raddr,
  input  wire logic [15:0]              ram_rdata,
  mrrc_result_if.source                 result
);

  logic                       out_valid;
  logic [mrrc_pkg::IDX_W-1:0] widx;
  mrrc_pkg::status_t          out_status;
  logic [7:0]                 out_exc;
  logic [2:0]                 out_idx;
  logic                       out_word;
  logic                       out_last;

  logic advance;
  logic issue;
  logic head_ok;

  assign advance   = !out_valid || result.ready;
  assign issue     = advance && !q_state.empty;
  assign head_ok   = (head.status == mrrc_pkg::ST_OK);
  assign pop       = issue && (!head_ok || (widx == mrrc_pkg::LAST_IDX));
  assign ram_re    = issue && head_ok;
  assign ram_raddr = head.bank
      ? mrrc_pkg::ADDR_W'(mrrc_pkg::REG_COUNT) + mrrc_pkg::ADDR_W'(widx)
      : mrrc_pkg::ADDR_W'(widx);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      widx      <= '0;
    end else if (advance) begin
      out_valid <= !q_state.empty;
      if (issue && head_ok) begin
        widx <= pop ? '0 : widx + mrrc_pkg::IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      out_status <= head.status;
      out_exc    <= head.exception_code;
      out_idx    <= head_ok ? 3'(widx) : 3'd0;
      out_word   <= head_ok;
      out_last   <= pop;
    end
  end

  assign result.valid          = out_valid;
  assign result.status         = out_status;
  assign result.exception_code = out_exc;
  assign result.reg_index      = out_idx;
  assign result.reg_value      = out_word ? ram_rdata : 16'h0000;
  assign result.last           = out_last;

endmodule
`default_nettype wire

// ----- hdl/mrrc_checker.sv -----
`default_nettype none
module mrrc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        res_valid,
  input wire logic        res_ready,
  input wire logic [2:0]  res_status,
  input wire logic [7:0]  res_exception_code,
  input wire logic [2:0]  res_reg_index,
  input wire logic [15:0] res_reg_value,
  input wire logic        res_last
);

  // Nothing is offered right after reset.
  a_reset_idle: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // A failed frame gives exactly one item, with empty word fields.
  a_error_single: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res_status != 3'd0)) |->
      (res_last && (res_reg_index == 3'd0) && (res_reg_value == 16'h0000)))
    else $error("error item malformed");

  // The exception code is only carried by exception items.
  a_exc_code: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res_status != 3'd3)) |-> (res_exception_code == 8'h00))
    else $error("exception code on non-exception item");

  // Words of one good frame follow without gaps and in index order.
  a_word_run: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_ready && !res_last) |=>
      (res_valid && (res_status == 3'd0) &&
       (res_reg_index == 3'($past(res_reg_index) + 3'd1))))
    else $error("word sequence broken");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=>
      (res_valid && $stable(res_status) && $stable(res_reg_value) &&
       $stable(res_reg_index) && $stable(res_last)))
    else $error("stalled result changed");

endmodule

bind modbus_read_response_checker_core mrrc_checker u_mrrc_checker (
  .clk                (clk),
  .rst                (rst),
  .res_valid          (result.valid),
  .res_ready          (result.ready),
  .res_status         (result.status),
  .res_exception_code (result.exception_code),
  .res_reg_index      (result.reg_index),
  .res_reg_value      (result.reg_value),
  .res_last           (result.last)
);
`default_nettype wire

// ----- tb/testbench.sv -----
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mrrc_pkg::*;

  // Cycles to let pass once the last expected result has come, before the
  // slave address is rewritten or the run ends. The block is fully pipelined
  // with a result register, so a handful of cycles is ample.
  localparam int SETTLE_CYCLES = 8;

  // Length of the one long receiver hold-off. It is far longer than the first
  // few directed frames take, so the result register and both queue slots
  // fill and the byte channel must stall.
  localparam int HOLD_OFF_CYCLES = 300;

  // Watchdog limit: cycles in a row without any transaction on any channel.
  // The longest legal quiet stretch is the hold-off above plus a few idle
  // cycles, so this leaves a wide margin.
  localparam int WATCHDOG_LIMIT = 2000;

  localparam int NUM_DIRECTED = 9;
  localparam int NUM_PHASES = 3;
  localparam int FRAMES_PER_PHASE = 1;
  localparam int MAX_REPORTS = 10;

  localparam logic [8:0] FULL_LEN = 9'(FULL_FRAME_LEN);

  // How the word area of a frame is filled.
  typedef enum logic [1:0] {
    FILL_RANDOM,
    FILL_ZERO,
    FILL_ONES
  } fill_t;

  // One frame to send. Bytes 0 to 2 come from the row, the rest from the fill.
  // When the frame reaches the CRC position the CRC is computed over the
  // first FULL_FRAME_LEN-2 bytes, spoiled if good_crc is low, and placed low
  // byte first. When typed is set, the status in want is what the frame
  // must give, written by hand instead of taken from the predictor.
  typedef struct packed {
    logic [8:0] frame_len;
    logic [7:0] address;
    logic [7:0] func;
    logic [7:0] count_field;
    logic       good_crc;
    fill_t      fill;
    logic       typed;
    status_t    want;
  } frame_row_t;

  // One result transaction as the block should send it.
  typedef struct {
    status_t     status;
    logic [7:0]  exception_code;
    logic [2:0]  reg_index;
    logic [15:0] reg_value;
    logic        last;
  } reg_result_t;

  // Directed frames. The slave address is still at its reset value of 1 here.
  // Error rows carry their status by hand; the good frame relies on the
  // predictor because its CRC needs to be worked out.
  localparam frame_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    // Good frame with all-zero words.
    '{FULL_LEN, SLAVE_RESET, FUNC_READ, BYTE_COUNT_OK, 1'b1, FILL_ZERO, 1'b0, ST_OK},
    // Short frames: a lone marked byte with a wrong address (short wins over
    // address), and one byte short of the minimum.
    '{9'd1, 8'hFF, FUNC_READ, BYTE_COUNT_OK, 1'b1, FILL_ZERO, 1'b1, ST_SHORT},
    '{9'd4, SLAVE_RESET, FUNC_READ, BYTE_COUNT_OK, 1'b1, FILL_ONES, 1'b1, ST_SHORT},
    // Minimum length with a read function is a length error.
    '{9'd5, SLAVE_RESET, FUNC_READ, BYTE_COUNT_OK, 1'b1, FILL_ZERO, 1'b1, ST_LENGTH},
    // Wrong slave address at the bottom extreme.
    '{9'd5, 8'h00, FUNC_READ, BYTE_COUNT_OK, 1'b1, FILL_ONES, 1'b1, ST_ADDRESS},
    // Exception responses carry the third byte out as the exception code.
    '{9'd5, SLAVE_RESET, FUNC_EXCEPTION, 8'hFF, 1'b1, FILL_ZERO, 1'b1, ST_EXCEPTION},
    // Unknown function code.
    '{9'd5, SLAVE_RESET, 8'h04, 8'h00, 1'b1, FILL_ONES, 1'b1, ST_FUNCTION},
    // Wrong byte count field, then a spoiled CRC.
    '{FULL_LEN, SLAVE_RESET, FUNC_READ, 8'h0F, 1'b1, FILL_RANDOM, 1'b1, ST_BYTE_COUNT},
    '{FULL_LEN, SLAVE_RESET, FUNC_READ, BYTE_COUNT_OK, 1'b0, FILL_RANDOM, 1'b1, ST_CRC}
  };

  logic clk = 1'b0;
  logic rst;

  mrrc_byte_if   rx_ch ();
  mrrc_result_if res_ch ();
  mrrc_cfg_if    cfg_ch ();

  modbus_read_response_checker_core u_top (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  always #10 clk = ~clk;

  // Parser state of the predictor, mirroring what the block keeps per frame.
  logic [7:0]  slave_setting;
  logic [7:0]  frm_len;
  logic [15:0] crc_acc;
  logic [15:0] crc_rx;
  logic [7:0]  addr_seen;
  logic [7:0]  func_seen;
  logic [7:0]  count_seen;
  logic [7:0]  high_seen;
  logic [15:0] word_store [REG_COUNT];

  reg_result_t expected_results [$];
  logic [7:0]  frame_bytes [$];

  int error_count = 0;
  int idle_pct = 36;
  int hold_left = 0;
  bit hold_off_pending = 1'b0;

  // Bit-serial CRC16: each input bit is folded in with the low CRC bit, and
  // the reflected polynomial is applied when the feedback bit is set.
  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic fb;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      fb = c[0] ^ b[k];
      c = c >> 1;
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  function automatic void clear_frame_state();
    frm_len = 8'd0;
    crc_acc = CRC_INIT;
    crc_rx = 16'h0000;
    addr_seen = 8'h00;
    func_seen = 8'h00;
    count_seen = 8'h00;
    high_seen = 8'h00;
  endfunction

  // Advances the predictor by one accepted byte. At the frame end it decides
  // the status in the block's order of checks and queues the results.
  function automatic void parse_frame_byte(input logic [7:0] b, input logic eof);
    int p;
    int d;
    status_t st;
    reg_result_t r;
    p = int'(frm_len);
    if (p == 0) begin
      addr_seen = b;
    end else if (p == 1) begin
      func_seen = b;
    end else if (p == 2) begin
      count_seen = b;
    end else if (p < FULL_FRAME_LEN - 2) begin
      // Words arrive high byte first; the low byte completes the word.
      d = p - 3;
      if (d % 2 == 0) begin
        high_seen = b;
      end else if (d / 2 < REG_COUNT) begin
        word_store[d / 2] = {high_seen, b};
      end
    end else if (p == FULL_FRAME_LEN - 2) begin
      crc_rx[7:0] = b;
    end else if (p == FULL_FRAME_LEN - 1) begin
      crc_rx[15:8] = b;
    end
    // The CRC covers everything up to the CRC field itself.
    if (p < FULL_FRAME_LEN - 2) begin
      crc_acc = crc16_step(crc_acc, b);
    end
    if (frm_len != LEN_MAX) begin
      frm_len = frm_len + 8'd1;
    end
    if (!eof) begin
      return;
    end

    if (frm_len < LEN_MIN) begin
      st = ST_SHORT;
    end else if (addr_seen != slave_setting) begin
      st = ST_ADDRESS;
    end else if (func_seen == FUNC_EXCEPTION) begin
      st = ST_EXCEPTION;
    end else if (func_seen != FUNC_READ) begin
      st = ST_FUNCTION;
    end else if (frm_len != LEN_EXACT) begin
      st = ST_LENGTH;
    end else if (count_seen != BYTE_COUNT_OK) begin
      st = ST_BYTE_COUNT;
    end else if (crc_rx != crc_acc) begin
      st = ST_CRC;
    end else begin
      st = ST_OK;
    end

    if (st != ST_OK) begin
      r.status = st;
      r.exception_code = (st == ST_EXCEPTION) ? count_seen : 8'h00;
      r.reg_index = 3'd0;
      r.reg_value = 16'h0000;
      r.last = 1'b1;
      expected_results.push_back(r);
    end else begin
      for (int i = 0; i < REG_COUNT; i++) begin
        r.status = ST_OK;
        r.exception_code = 8'h00;
        r.reg_index = 3'(i);
        r.reg_value = word_store[i];
        r.last = (i == REG_COUNT - 1);
        expected_results.push_back(r);
      end
    end
    clear_frame_state();
  endfunction

  // Offers one byte, sometimes after a short random gap, and waits for the
  // transaction. The predictor is advanced in the cycle of acceptance, which
  // is always before the block can answer with a result.
  task automatic send_byte(input logic [7:0] b, input logic eof);
    if ($urandom_range(99) < idle_pct) begin
      rx_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    rx_ch.valid <= 1'b1;
    rx_ch.rx_byte <= b;
    rx_ch.end_of_frame <= eof;
    do @(posedge clk); while (rx_ch.ready !== 1'b1);
    parse_frame_byte(b, eof);
  endtask

  // Lays out the bytes of one frame as the row describes.
  task automatic build_frame(input frame_row_t row);
    logic [15:0] c;
    logic [7:0] v;
    frame_bytes.delete();
    for (int n = 0; n < int'(row.frame_len); n++) begin
      case (n)
        0: v = row.address;
        1: v = row.func;
        2: v = row.count_field;
        default: begin
          case (row.fill)
            FILL_ZERO: v = 8'h00;
            FILL_ONES: v = 8'hFF;
            default:   v = 8'($urandom_range(255));
          endcase
        end
      endcase
      frame_bytes.push_back(v);
    end
    if (int'(row.frame_len) >= FULL_FRAME_LEN) begin
      c = CRC_INIT;
      for (int n = 0; n < FULL_FRAME_LEN - 2; n++) begin
        c = crc16_step(c, frame_bytes[n]);
      end
      if (!row.good_crc) begin
        c = c ^ (16'h0001 << $urandom_range(15));
      end
      frame_bytes[FULL_FRAME_LEN - 2] = c[7:0];
      frame_bytes[FULL_FRAME_LEN - 1] = c[15:8];
    end
  endtask

  task automatic send_frame(input frame_row_t row);
    reg_result_t r;
    build_frame(row);
    foreach (frame_bytes[n]) begin
      send_byte(frame_bytes[n], n == frame_bytes.size() - 1);
    end
    // For hand-checked rows the typed status replaces what the predictor
    // queued. This happens in the cycle of the last transaction, so the
    // result cannot have left the block yet.
    if (row.typed) begin
      r.status = row.want;
      r.exception_code = (row.want == ST_EXCEPTION) ? row.count_field : 8'h00;
      r.reg_index = 3'd0;
      r.reg_value = 16'h0000;
      r.last = 1'b1;
      expected_results[expected_results.size() - 1] = r;
    end
  endtask

  // Mostly well-formed frames with random words; the rest break one check
  // at a time, or are plain noise.
  function automatic frame_row_t pick_random_frame();
    frame_row_t row;
    int pick;
    pick = $urandom_range(99);
    row = '{FULL_LEN, slave_setting, FUNC_READ, BYTE_COUNT_OK, 1'b1, FILL_RANDOM, 1'b0,
            ST_OK};
    if (pick < 55) begin
      if ($urandom_range(9) == 0) begin
        row.fill = fill_t'($urandom_range(2));
      end
    end else if (pick < 64) begin
      row.good_crc = 1'b0;
    end else if (pick < 70) begin
      row.func = FUNC_EXCEPTION;
      row.count_field = 8'($urandom_range(255));
      row.frame_len = 9'($urandom_range(5, FULL_FRAME_LEN + 2));
    end else if (pick < 75) begin
      row.address = slave_setting + 8'($urandom_range(1, 255));
    end else if (pick < 80) begin
      do row.func = 8'($urandom_range(255));
      while (row.func == FUNC_READ || row.func == FUNC_EXCEPTION);
    end else if (pick < 85) begin
      do row.count_field = 8'($urandom_range(255)); while (row.count_field == BYTE_COUNT_OK);
    end else if (pick < 90) begin
      do row.frame_len = 9'($urandom_range(5, FULL_FRAME_LEN + 6));
      while (row.frame_len == FULL_LEN);
    end else if (pick < 95) begin
      row.frame_len = 9'($urandom_range(1, 4));
    end else begin
      row.frame_len = 9'($urandom_range(1, 40));
      row.address = 8'($urandom_range(255));
      row.func = 8'($urandom_range(255));
      row.count_field = 8'($urandom_range(255));
      row.good_crc = 1'($urandom_range(1));
    end
    return row;
  endfunction

  // Stops offering bytes and waits until every expected result has come,
  // then lets the block settle.
  task automatic drain_results();
    rx_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Rewrites the slave address; only called with the block idle.
  task automatic write_slave_address(input logic [7:0] a);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= a;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    slave_setting = a;
  endtask

  // Main stimulus: reset, the directed table, then random phases, each one
  // opened by a write of the slave address.
  initial begin
    logic [7:0] phase_addr;
    rst <= 1'b1;
    rx_ch.valid <= 1'b0;
    rx_ch.rx_byte <= 8'h00;
    rx_ch.end_of_frame <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data <= 8'h00;
    slave_setting = SLAVE_RESET;
    clear_frame_state();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The receiver holds off for a long time while the directed frames keep
    // coming, so the frame queue fills and the byte channel stalls.
    hold_off_pending = 1'b1;
    foreach (DIRECTED_ROWS[i]) begin
      send_frame(DIRECTED_ROWS[i]);
    end
    // The sender pauses here until every result of the table has come.
    drain_results();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // The two extremes first, then random addresses.
      case (ph)
        0: phase_addr = 8'h00;
        1: phase_addr = 8'hFF;
        default: phase_addr = 8'($urandom_range(255));
      endcase
      if (ph != 0) begin
        drain_results();
      end
      write_slave_address(phase_addr);
      // The later phases run with no idling at all.
      idle_pct = (ph == 0) ? 36 : 0;
      for (int f = 0; f < FRAMES_PER_PHASE; f++) begin
        send_frame(pick_random_frame());
      end
    end

    drain_results();
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Result side: checks every transaction against the oldest expectation and
  // drives ready, with random idling and the one long hold-off.
  initial begin
    reg_result_t want;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
        if (expected_results.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("unexpected result: status %0d exc %02h idx %0d value %04h last %0b",
                     res_ch.status, res_ch.exception_code, res_ch.reg_index,
                     res_ch.reg_value, res_ch.last);
          end
        end else begin
          want = expected_results.pop_front();
          if (res_ch.status !== want.status || res_ch.exception_code !== want.exception_code ||
              res_ch.reg_index !== want.reg_index || res_ch.reg_value !== want.reg_value ||
              res_ch.last !== want.last) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
              $display("result mismatch: expected status %0d exc %02h idx %0d value %04h last %0b",
                       want.status, want.exception_code, want.reg_index, want.reg_value,
                       want.last);
              $display("                 actual   status %0d exc %02h idx %0d value %04h last %0b",
                       res_ch.status, res_ch.exception_code, res_ch.reg_index,
                       res_ch.reg_value, res_ch.last);
            end
          end
        end
      end
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  // Watchdog: ends the run if no channel moves for too long.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((rx_ch.valid === 1'b1 && rx_ch.ready === 1'b1) ||
          (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) ||
          (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

endmodule
`default_nettype wire
